@@ rtl/stbs_pkg.sv @@
// Shared types and constants for the sorted-table binary search block.
`default_nettype none
package stbs_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 10;
    localparam int COUNT_W         = 11;
    localparam int POS_W           = 10;
    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // write one table entry
        logic init;       // start a search: latch key, set bounds
        logic probe;      // read the midpoint entry
        logic miss;       // window empty: key absent
        logic hit;        // probed entry equals key
        logic go_lower;   // key below probed entry
        logic go_upper;   // key above probed entry
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;      // low bound has reached high bound
        logic key_eq;
        logic key_lt;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ rtl/stbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/stbs_dp.sv @@
// Search datapath: table memory, bounds, key compare and result registers.
`default_nettype none
module stbs_dp
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [COUNT_W-1:0]       i_cfg_wdata,
    input  wire logic [IDX_W-1:0]         i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    output logic                          o_found,
    output logic [POS_W-1:0]              o_position
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int UW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int IXW  = (AW + 1 > IDX_W + 1) ? AW + 1 : IDX_W + 1;

    logic [COUNT_W-1:0]       r_entry_count;
    logic signed [DATA_W-1:0] r_key;
    logic [CW-1:0]            r_low,   n_low;
    logic [CW-1:0]            r_hi_ex, n_hi_ex;   // exclusive upper bound
    logic [AW-1:0]            r_mid;
    logic                     r_found;
    logic [POS_W-1:0]         r_position;

    logic [UW-1:0]            w_cnt_ext;
    logic [CW-1:0]            w_used;
    logic [CW:0]              w_sum;
    logic [AW-1:0]            w_mid;
    logic                     w_idx_ok;
    logic [DATA_W-1:0]        w_rdata;
    logic signed [DATA_W-1:0] w_probe;

    // search window size, saturated at the table depth
    assign w_cnt_ext = UW'(r_entry_count);
    assign w_used    = (w_cnt_ext > UW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_entry_count);

    // floor((low + high) / 2) with high = hi_ex - 1; low < hi_ex when used
    assign w_sum = {1'b0, r_low} + {1'b0, r_hi_ex} - (CW + 1)'(1);
    assign w_mid = AW'(w_sum[CW:1]);

    assign w_idx_ok = IXW'(i_entry_index) < IXW'(TABLE_DEPTH);

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_idx_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_data_value),
        .i_raddr (w_mid),
        .o_rdata (w_rdata)
    );

    assign w_probe       = $signed(w_rdata);
    assign o_stat.empty  = !(r_low < r_hi_ex);
    assign o_stat.key_eq = (r_key == w_probe);
    assign o_stat.key_lt = (r_key < w_probe);

    always_comb begin
        n_low   = r_low;
        n_hi_ex = r_hi_ex;
        if (i_cmd.init) begin
            n_low   = '0;
            n_hi_ex = w_used;
        end else if (i_cmd.go_lower) begin
            n_hi_ex = CW'(r_mid);
        end else if (i_cmd.go_upper) begin
            n_low = CW'(r_mid) + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low   <= n_low;
        r_hi_ex <= n_hi_ex;
        if (i_cmd.init) begin
            r_key <= i_data_value;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.miss) begin
            r_found    <= 1'b0;
            r_position <= '0;
        end else if (i_cmd.hit) begin
            r_found    <= 1'b1;
            r_position <= POS_W'(r_mid);
        end
    end

    assign o_found    = r_found;
    assign o_position = r_position;

endmodule
`default_nettype wire

@@ rtl/stbs_ctrl.sv @@
// Search controller: sequences probe reads and compares.
`default_nettype none
module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic     i_action,
    input  wire t_dp_stat i_stat,
    output logic          busy,
    output logic          o_done,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_SEARCH) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (i_stat.empty) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.key_eq) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_DONE;
                end else if (i_stat.key_lt) begin
                    o_cmd.go_lower = 1'b1;
                    n_state        = S_READ;
                end else begin
                    o_cmd.go_upper = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
`default_nettype wire

@@ rtl/sorted_table_binary_search.sv @@
// Top level: binary search over a sorted table of signed 32-bit entries.
// Load beat: written at the accepting edge, busy never rises; one beat per cycle while not busy.
// Search beat: each probe is a registered table read (READ), then a compare (CMP).
//   A hit after p probes ends from CMP; a miss ends from a READ that finds the window empty.
//   p <= floor(log2(count)) + 1, with count saturated at the table depth; DONE then frees the block.
// Sync active-low reset clears the controller and entry_count; table is not cleared.
`default_nettype none
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // config: entry_count register
    input  wire logic                     i_cfg_we,
    input  wire logic [COUNT_W-1:0]       i_cfg_wdata,
    // command beat
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_action,
    input  wire logic [IDX_W-1:0]         i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    // result beat, one-cycle strobe, cannot be stalled
    output logic                          o_done,
    output logic                          o_found,
    output logic [POS_W-1:0]              o_position
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Controller walks IDLE -> READ -> CMP -> (READ ...) -> DONE on a search; a load stays in IDLE.
    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (w_stat),
        .busy     (busy),
        .o_done   (o_done),
        .o_cmd    (w_cmd)
    );

    // Datapath keeps [low, hi_ex) as the live window; the midpoint
    // addresses the table RAM directly, read data lands in the next cycle.
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_data_value  (i_data_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    // A not-found result always reports position zero.
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_position == '0))
        else $error("miss result with nonzero position");

    // An accepted search holds busy on the next cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_SEARCH) |=> busy)
        else $error("search accepted but busy not raised");

    // A load never occupies the block.
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_LOAD) |=> !busy)
        else $error("load raised busy");

    // The result strobe lasts one cycle and busy drops right after.
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not a single cycle");

endmodule
`default_nettype wire
